/* hdl/gyro_yaw_integrator_defines.svh */
// Assertion macros for the yaw integrator checker.
`ifndef GYRO_YAW_INTEGRATOR_DEFINES_SVH
`define GYRO_YAW_INTEGRATOR_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define GYI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Trigger in one cycle, consequence in the next.
`define GYI_ASSERT_NEXT(lbl, trig, cons, msg) \
	`GYI_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

/* hdl/gyi_pkg.sv */
`default_nettype none

package gyi_pkg;

	localparam int RAD_W     = 23;
	localparam int ACC_W     = 25;
	localparam int TS_W      = 32;
	localparam int YV_W      = 26;
	localparam int YAW_OUT_W = 25;
	localparam int RATE_W    = 29;
	localparam int ACCG_W    = 22;
	localparam int CFG_W     = 16;
	localparam int CNT_W     = 16;
	localparam int SUM_W     = 48;
	localparam int DIVN_W    = CNT_W + 1;
	localparam int DIV_CNT_W = 6;
	localparam int YAW_W     = 27;
	localparam int DIFF_W    = 30;
	localparam int MUL_A_W   = 29;
	localparam int MUL_B_W   = 24;
	localparam int MUL_W     = MUL_A_W + MUL_B_W;
	localparam int Q_SHIFT   = 16;
	localparam int MS_SHIFT  = 32;

	localparam logic [1:0] CMD_CAL    = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_RESET  = 2'd2;

	localparam logic [CFG_W-1:0] CAL_SAMPLES_RST = 16'd1000;

	// deg per rad, ms to s (Q0.32), 1/g (Q0.16)
	localparam logic signed [MUL_B_W-1:0] DPS_K   = 24'sd3754936;
	localparam logic signed [MUL_B_W-1:0] MS_K    = 24'sd4294967;
	localparam logic signed [MUL_B_W-1:0] INV_G_K = 24'sd6683;

	localparam logic signed [YAW_W-1:0]  DEG180     = 27'sd11796480;
	localparam logic signed [YAW_W-1:0]  DEG360     = 27'sd23592960;
	localparam logic signed [DIFF_W-1:0] RATE_LIMIT = 30'sd262144000;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_RATE,
		S_DPS,
		S_CAL_ADD,
		S_DIV_INIT,
		S_DIV,
		S_DIV_END,
		S_RATE,
		S_MUL_INC,
		S_INC,
		S_YAW_LOAD,
		S_WRAP,
		S_ACCEL,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_RATE,
		MUL_INC,
		MUL_ACCEL
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     dps_load;
		logic     cal_add;
		logic     rate_upd;
		logic     inc_add;
		logic     yaw_load;
		logic     wrap_step;
		logic     div_init;
		logic     div_step;
		logic     div_end;
		logic     out_load;
	} dp_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       bias_valid;
		logic       cal_complete;
		logic       yaw_in_range;
		logic       div_last;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hdl/gyi_ctrl.sv */
`default_nettype none

module gyi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output gyi_pkg::dp_ctl_t     ctl,
	input  wire gyi_pkg::dp_sts_t sts
);

	gyi_pkg::state_t state_q;
	gyi_pkg::state_t state_next;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gyi_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != gyi_pkg::S_IDLE);

	always_comb begin
		state_next = state_q;
		ctl        = '0;
		ctl.mul_sel = gyi_pkg::MUL_RATE;
		case (state_q)
			gyi_pkg::S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_next  = gyi_pkg::S_MUL_RATE;
				end
			end
			gyi_pkg::S_MUL_RATE: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = gyi_pkg::MUL_RATE;
				state_next  = gyi_pkg::S_DPS;
			end
			gyi_pkg::S_DPS: begin
				ctl.dps_load = 1'b1;
				case (sts.cmd)
					gyi_pkg::CMD_CAL: begin
						state_next = gyi_pkg::S_CAL_ADD;
					end
					gyi_pkg::CMD_UPDATE: begin
						state_next = sts.bias_valid ? gyi_pkg::S_RATE : gyi_pkg::S_ACCEL;
					end
					gyi_pkg::CMD_RESET: begin
						state_next = gyi_pkg::S_YAW_LOAD;
					end
					default: begin
						state_next = gyi_pkg::S_ACCEL;
					end
				endcase
			end
			gyi_pkg::S_CAL_ADD: begin
				ctl.cal_add = 1'b1;
				state_next  = sts.cal_complete ? gyi_pkg::S_DIV_INIT : gyi_pkg::S_ACCEL;
			end
			gyi_pkg::S_DIV_INIT: begin
				ctl.div_init = 1'b1;
				state_next   = gyi_pkg::S_DIV;
			end
			gyi_pkg::S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = gyi_pkg::S_DIV_END;
				end
			end
			gyi_pkg::S_DIV_END: begin
				ctl.div_end = 1'b1;
				state_next  = gyi_pkg::S_ACCEL;
			end
			gyi_pkg::S_RATE: begin
				ctl.rate_upd = 1'b1;
				state_next   = gyi_pkg::S_MUL_INC;
			end
			gyi_pkg::S_MUL_INC: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = gyi_pkg::MUL_INC;
				state_next  = gyi_pkg::S_INC;
			end
			gyi_pkg::S_INC: begin
				ctl.inc_add = 1'b1;
				state_next  = gyi_pkg::S_WRAP;
			end
			gyi_pkg::S_YAW_LOAD: begin
				ctl.yaw_load = 1'b1;
				state_next   = gyi_pkg::S_WRAP;
			end
			gyi_pkg::S_WRAP: begin
				if (sts.yaw_in_range) begin
					state_next = gyi_pkg::S_ACCEL;
				end else begin
					ctl.wrap_step = 1'b1;
				end
			end
			gyi_pkg::S_ACCEL: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_sel = gyi_pkg::MUL_ACCEL;
				state_next  = gyi_pkg::S_OUT;
			end
			gyi_pkg::S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_next   = gyi_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = gyi_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/gyi_dpath.sv */
`default_nettype none

module gyi_dpath #(
	parameter int MIN_STEP_MS = 1,
	parameter int MAX_STEP_MS = 20
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gyi_pkg::dp_ctl_t                     ctl,
	output gyi_pkg::dp_sts_t                          sts,
	input  wire logic                                 cfg_we,
	input  wire logic [gyi_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic [1:0]                           cmd,
	input  wire logic signed [gyi_pkg::RAD_W-1:0]     rate_rad,
	input  wire logic signed [gyi_pkg::ACC_W-1:0]     accel_in,
	input  wire logic [gyi_pkg::TS_W-1:0]             timestamp_ms,
	input  wire logic signed [gyi_pkg::YV_W-1:0]      yaw_value,
	output logic                                      status,
	output logic signed [gyi_pkg::YAW_OUT_W-1:0]      yaw_out,
	output logic signed [gyi_pkg::RATE_W-1:0]         rate_dps,
	output logic signed [gyi_pkg::ACC_W-1:0]          accel_out,
	output logic signed [gyi_pkg::ACCG_W-1:0]         accel_g,
	output logic                                      bias_locked,
	output logic                                      calibration_done
);

	localparam int DT_W    = $clog2(MAX_STEP_MS + 1);
	localparam int INC_RAW = gyi_pkg::MUL_W + DT_W + 1;
	localparam int INC_MIN = gyi_pkg::MS_SHIFT + gyi_pkg::YAW_W;
	localparam int INC_W   = (INC_RAW > INC_MIN) ? INC_RAW : INC_MIN;

	// architectural state
	logic [gyi_pkg::CFG_W-1:0]         cal_samples_q;
	logic signed [gyi_pkg::RATE_W-1:0] bias_q;
	logic signed [gyi_pkg::SUM_W-1:0]  sum_q;
	logic [gyi_pkg::CNT_W-1:0]         cnt_q;
	logic                              bias_valid_q;
	logic signed [gyi_pkg::YAW_W-1:0]  yaw_q;
	logic [gyi_pkg::TS_W-1:0]          last_ts_q;
	logic signed [gyi_pkg::RATE_W-1:0] last_rate_q;
	logic signed [gyi_pkg::ACC_W-1:0]  last_accel_q;

	// working registers
	logic [1:0]                         cmd_q;
	logic signed [gyi_pkg::RAD_W-1:0]   rad_q;
	logic signed [gyi_pkg::ACC_W-1:0]   acc_q;
	logic [gyi_pkg::TS_W-1:0]           ts_q;
	logic signed [gyi_pkg::YV_W-1:0]    yv_q;
	logic signed [gyi_pkg::MUL_W-1:0]   mul_q;
	logic signed [gyi_pkg::RATE_W-1:0]  dps_q;
	logic [DT_W-1:0]                    dt_q;
	logic [gyi_pkg::DIVN_W-1:0]         div_n_q;
	logic [gyi_pkg::SUM_W-1:0]          quo_q;
	logic [gyi_pkg::DIVN_W-1:0]         rem_q;
	logic [gyi_pkg::DIV_CNT_W-1:0]      div_cnt_q;
	logic                               sum_neg_q;
	logic                               cal_done_q;

	// output register
	logic                                 status_q;
	logic signed [gyi_pkg::YAW_OUT_W-1:0] yaw_out_q;
	logic signed [gyi_pkg::RATE_W-1:0]    rate_dps_q;
	logic signed [gyi_pkg::ACC_W-1:0]     accel_out_q;
	logic signed [gyi_pkg::ACCG_W-1:0]    accel_g_q;
	logic                                 bias_locked_q;
	logic                                 cal_out_q;

	logic signed [gyi_pkg::MUL_A_W-1:0] mul_a;
	logic signed [gyi_pkg::MUL_B_W-1:0] mul_b;
	logic signed [gyi_pkg::MUL_W-1:0]   mul_p;
	logic signed [INC_W-1:0]            inc_p;
	logic signed [gyi_pkg::YAW_W-1:0]   inc;
	logic [gyi_pkg::CNT_W-1:0]          cnt_inc;
	logic [gyi_pkg::CNT_W-1:0]          target;
	logic [gyi_pkg::DIVN_W-1:0]         div_n_next;
	logic [gyi_pkg::DIVN_W:0]           div_sh;
	logic [gyi_pkg::DIVN_W:0]           div_sub;
	logic                               div_ge;
	logic [gyi_pkg::SUM_W-1:0]          sum_abs;
	logic signed [gyi_pkg::RATE_W-1:0]  quo_s;
	logic [gyi_pkg::TS_W-1:0]           ts_diff;
	logic [DT_W-1:0]                    dt_next;
	logic signed [gyi_pkg::DIFF_W-1:0]  diff;
	logic signed [gyi_pkg::DIFF_W-1:0]  diff_sat;
	logic                               yaw_gt;
	logic                               yaw_lt;

	always_comb begin
		case (ctl.mul_sel)
			gyi_pkg::MUL_RATE: begin
				mul_a = gyi_pkg::MUL_A_W'(rad_q);
				mul_b = gyi_pkg::DPS_K;
			end
			gyi_pkg::MUL_INC: begin
				mul_a = gyi_pkg::MUL_A_W'(last_rate_q);
				mul_b = gyi_pkg::MS_K;
			end
			gyi_pkg::MUL_ACCEL: begin
				mul_a = gyi_pkg::MUL_A_W'(last_accel_q);
				mul_b = gyi_pkg::INV_G_K;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = gyi_pkg::MUL_W'(mul_a) * gyi_pkg::MUL_W'(mul_b);
	assign inc_p = INC_W'(mul_q) * INC_W'($signed({1'b0, dt_q}));
	assign inc   = $signed(inc_p[gyi_pkg::MS_SHIFT +: gyi_pkg::YAW_W]);

	assign cnt_inc    = cnt_q + gyi_pkg::CNT_W'(1);
	assign target     = (cal_samples_q == '0) ? gyi_pkg::CNT_W'(1) : cal_samples_q;
	assign div_n_next = (cnt_inc == '0) ? {1'b1, {gyi_pkg::CNT_W{1'b0}}} : {1'b0, cnt_inc};

	assign div_sh  = {rem_q, quo_q[gyi_pkg::SUM_W-1]};
	assign div_ge  = (div_sh >= {1'b0, div_n_q});
	assign div_sub = div_sh - {1'b0, div_n_q};
	assign sum_abs = sum_q[gyi_pkg::SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign quo_s   = $signed(quo_q[gyi_pkg::RATE_W-1:0]);

	assign ts_diff = ts_q - last_ts_q;
	assign dt_next = (ts_diff < gyi_pkg::TS_W'(MIN_STEP_MS)) ? DT_W'(MIN_STEP_MS) :
		(ts_diff > gyi_pkg::TS_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS) : ts_diff[DT_W-1:0];

	assign diff     = gyi_pkg::DIFF_W'(dps_q) - gyi_pkg::DIFF_W'(bias_q);
	assign diff_sat = (diff > gyi_pkg::RATE_LIMIT) ? gyi_pkg::RATE_LIMIT :
		(diff < -gyi_pkg::RATE_LIMIT) ? -gyi_pkg::RATE_LIMIT : diff;

	assign yaw_gt = (yaw_q > gyi_pkg::DEG180);
	assign yaw_lt = (yaw_q < -gyi_pkg::DEG180);

	assign sts.cmd          = cmd_q;
	assign sts.bias_valid   = bias_valid_q;
	assign sts.cal_complete = (cnt_inc >= target) || (cnt_inc == '0);
	assign sts.yaw_in_range = !yaw_gt && !yaw_lt;
	assign sts.div_last     = (div_cnt_q == gyi_pkg::DIV_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_samples_q <= gyi_pkg::CAL_SAMPLES_RST;
			bias_q        <= '0;
			sum_q         <= '0;
			cnt_q         <= '0;
			bias_valid_q  <= 1'b0;
			yaw_q         <= '0;
			last_ts_q     <= '0;
			last_rate_q   <= '0;
			last_accel_q  <= '0;
		end else begin
			if (cfg_we) begin
				cal_samples_q <= cfg_data;
			end
			if (ctl.cal_add) begin
				sum_q <= sum_q + gyi_pkg::SUM_W'(dps_q);
				cnt_q <= cnt_inc;
			end
			if (ctl.div_init) begin
				sum_q        <= '0;
				cnt_q        <= '0;
				yaw_q        <= '0;
				last_rate_q  <= '0;
				last_accel_q <= '0;
				bias_valid_q <= 1'b1;
				last_ts_q    <= ts_q;
			end
			if (ctl.div_end) begin
				bias_q <= sum_neg_q ? -quo_s : quo_s;
			end
			if (ctl.rate_upd) begin
				last_rate_q  <= gyi_pkg::RATE_W'(diff_sat);
				last_accel_q <= acc_q;
				last_ts_q    <= ts_q;
			end
			if (ctl.inc_add) begin
				yaw_q <= yaw_q + inc;
			end
			if (ctl.yaw_load) begin
				yaw_q     <= gyi_pkg::YAW_W'(yv_q);
				last_ts_q <= ts_q;
			end
			if (ctl.wrap_step) begin
				yaw_q <= yaw_gt ? (yaw_q - gyi_pkg::DEG360) : (yaw_q + gyi_pkg::DEG360);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q      <= cmd;
			rad_q      <= rate_rad;
			acc_q      <= accel_in;
			ts_q       <= timestamp_ms;
			yv_q       <= yaw_value;
			cal_done_q <= 1'b0;
		end
		if (ctl.mul_en) begin
			mul_q <= mul_p;
		end
		if (ctl.dps_load) begin
			dps_q <= $signed(mul_q[gyi_pkg::Q_SHIFT +: gyi_pkg::RATE_W]);
		end
		if (ctl.cal_add) begin
			div_n_q <= div_n_next;
		end
		if (ctl.rate_upd) begin
			dt_q <= dt_next;
		end
		if (ctl.div_init) begin
			quo_q      <= sum_abs;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			sum_neg_q  <= sum_q[gyi_pkg::SUM_W-1];
			cal_done_q <= 1'b1;
		end
		if (ctl.div_step) begin
			rem_q     <= div_ge ? div_sub[gyi_pkg::DIVN_W-1:0] : div_sh[gyi_pkg::DIVN_W-1:0];
			quo_q     <= {quo_q[gyi_pkg::SUM_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q + gyi_pkg::DIV_CNT_W'(1);
		end
		if (ctl.out_load) begin
			status_q      <= (cmd_q == gyi_pkg::CMD_UPDATE) && !bias_valid_q;
			yaw_out_q     <= yaw_q[gyi_pkg::YAW_OUT_W-1:0];
			rate_dps_q    <= last_rate_q;
			accel_out_q   <= last_accel_q;
			accel_g_q     <= $signed(mul_q[gyi_pkg::Q_SHIFT +: gyi_pkg::ACCG_W]);
			bias_locked_q <= bias_valid_q;
			cal_out_q     <= cal_done_q;
		end
	end

	assign status           = status_q;
	assign yaw_out          = yaw_out_q;
	assign rate_dps         = rate_dps_q;
	assign accel_out        = accel_out_q;
	assign accel_g          = accel_g_q;
	assign bias_locked      = bias_locked_q;
	assign calibration_done = cal_out_q;

endmodule

`default_nettype wire

/* hdl/gyro_yaw_integrator.sv */
// Z-axis yaw integrator with gyro bias calibration, Q16.16 throughout.
// Input channel: in_valid with in_stall; a request is taken on a clock edge
// where in_valid is high and in_stall is low. cmd 0 adds a calibration sample,
// cmd 1 integrates one update sample, cmd 2 loads a new yaw.
// Output channel: out_valid with out_stall; one result per request, held in an
// output register until taken. A stalled result blocks only the next result:
// the following request is still accepted and worked on.
// Config channel: cfg_valid/cfg_ready writes calibration_samples; cfg_ready
// is always high. Write it only while the block is idle.
// Every request is captured, scaled to deg/s and ends with the accel multiply
// and the output load; a refused update or unused cmd does nothing more, a
// calibration sample adds to the sum, a yaw load and an update wrap the yaw by
// 360 as needed, and the sample that completes a calibration run runs the
// 48-step bit-serial bias divider. One request is in work at a time; the next
// is accepted the cycle after the result is loaded into the output register.
// Reset (arst_n low) clears bias, sums, yaw and timestamps, sets
// calibration_samples to 1000 and drops out_valid.
`default_nettype none

module gyro_yaw_integrator #(
	parameter int MIN_STEP_MS = 1,
	parameter int MAX_STEP_MS = 20
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [gyi_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           cmd,
	input  wire logic signed [gyi_pkg::RAD_W-1:0]     rate_rad,
	input  wire logic signed [gyi_pkg::ACC_W-1:0]     accel_in,
	input  wire logic [gyi_pkg::TS_W-1:0]             timestamp_ms,
	input  wire logic signed [gyi_pkg::YV_W-1:0]      yaw_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      status,
	output logic signed [gyi_pkg::YAW_OUT_W-1:0]      yaw_out,
	output logic signed [gyi_pkg::RATE_W-1:0]         rate_dps,
	output logic signed [gyi_pkg::ACC_W-1:0]          accel_out,
	output logic signed [gyi_pkg::ACCG_W-1:0]         accel_g,
	output logic                                      bias_locked,
	output logic                                      calibration_done
);

	gyi_pkg::dp_ctl_t ctl;
	gyi_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	gyi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	gyi_dpath #(
		.MIN_STEP_MS (MIN_STEP_MS),
		.MAX_STEP_MS (MAX_STEP_MS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.sts              (sts),
		.cfg_we           (cfg_valid),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.rate_rad         (rate_rad),
		.accel_in         (accel_in),
		.timestamp_ms     (timestamp_ms),
		.yaw_value        (yaw_value),
		.status           (status),
		.yaw_out          (yaw_out),
		.rate_dps         (rate_dps),
		.accel_out        (accel_out),
		.accel_g          (accel_g),
		.bias_locked      (bias_locked),
		.calibration_done (calibration_done)
	);

endmodule

`default_nettype wire

/* hdl/gyi_checker.sv */
`default_nettype none
`include "gyro_yaw_integrator_defines.svh"

module gyi_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic                                 status,
	input wire logic signed [gyi_pkg::YAW_OUT_W-1:0] yaw_out,
	input wire logic                                 bias_locked,
	input wire logic                                 calibration_done
);

	`GYI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(yaw_out), "result moved")

	`GYI_ASSERT(a_refused, out_valid && status |-> !bias_locked && !calibration_done, "refused w/ bias")

	`GYI_ASSERT(a_cal_done, out_valid && calibration_done |-> bias_locked && !status && yaw_out == '0, "cal end")

	`GYI_ASSERT(a_yaw_range, out_valid |-> yaw_out <= gyi_pkg::DEG180 && yaw_out >= -gyi_pkg::DEG180, "yaw range")

	`GYI_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "request taken while busy")

endmodule

bind gyro_yaw_integrator gyi_checker u_gyi_checker (.*);

`default_nettype wire
